// ----- rtl/srg_pkg.sv -----
// Shared types and constants for the subtractive random generator.
// No dependencies; imported by srg_ram and subtractive_random_generator.
package srg_pkg;

    localparam int WORD_W     = 31;
    localparam int ADDR_W     = 6;
    localparam int TABLE_LEN  = 55;
    localparam int RAM_DEPTH  = TABLE_LEN + 1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Seed base, draw multiplier and increment, scatter step, lag start
    localparam word_t SEED_BASE    = 31'd161803398;
    localparam logic [16:0] DRAW_MUL = 17'd84589;
    localparam word_t DRAW_ADD     = 31'd45989;
    localparam addr_t SCATTER_STEP = 6'd21;
    localparam addr_t LAST_POS     = 6'd55;
    localparam addr_t LAST_SCATTER = 6'd54;
    localparam addr_t LAG_START    = 6'd31;
    localparam addr_t LAG_SPLIT    = 6'd24;
    localparam addr_t LAG_FWD      = 6'd31;
    localparam addr_t LAG_BACK     = 6'd24;

endpackage

// ----- rtl/srg_ram.sv -----
// Lag table storage: one write port, two read ports, registered read data.
// Depends on srg_pkg for word and address types.
module srg_ram (
    input  logic          aclk,
    input  logic          wr_en,
    input  srg_pkg::addr_t wr_addr,
    input  srg_pkg::word_t wr_data,
    input  srg_pkg::addr_t rd_addr_a,
    input  srg_pkg::addr_t rd_addr_b,
    output srg_pkg::word_t rd_data_a,
    output srg_pkg::word_t rd_data_b
);
    import srg_pkg::*;

    word_t mem [RAM_DEPTH];
    word_t rd_data_a_reg;
    word_t rd_data_b_reg;

    // Write one word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read two words, registered
    always_ff @(posedge aclk) begin
        rd_data_a_reg <= mem[rd_addr_a];
        rd_data_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ----- rtl/subtractive_random_generator.sv -----
// Lagged subtractive random generator (ran3 style) over a 55-word lag table.
// Depends on srg_pkg and srg_ram.
//
// A beat with s_tuser = 1 draws the next 31-bit word (fraction = word / 2^31) and
// returns it on the m_ side; a beat with s_tuser = 0 reseeds the table from the
// signed seed in s_tdata and returns nothing. The block handles one beat at a
// time: a draw runs a table read, one shared 31-bit subtractor, a registered
// 31x17 multiply, then add and write back, and waits at write back while the
// output register holds an untaken word; a seed runs the start value and scatter
// walk (55 writes) and four mixing passes of 54 read/subtract/write steps
// through the same subtractor and the table's single write port. After reset the
// block runs the same seeding with seed 0 and holds s_tready low until it is done.
// A finished word waits in the output register while the next beat is taken.
module subtractive_random_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed (signed)
    input  logic        s_tuser,   // [0] mode: 0 seed, 1 draw
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [30:0] value, [31] zero
);
    import srg_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SEED     = 8'b0000_0010,
        S_SCAT     = 8'b0000_0100,
        S_MIX_RD   = 8'b0000_1000,
        S_MIX_WR   = 8'b0001_0000,
        S_DRAW_SUB = 8'b0010_0000,
        S_DRAW_MUL = 8'b0100_0000,
        S_DRAW_WR  = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    word_t       mag_reg, mag_next;
    word_t       m_reg, m_next;
    word_t       k_reg, k_next;
    addr_t       pos_reg, pos_next;
    addr_t       cnt_reg, cnt_next;
    logic [1:0]  pass_reg, pass_next;
    addr_t       read_index_reg, read_index_next;
    addr_t       lag_index_reg, lag_index_next;
    word_t       diff_reg, diff_next;
    word_t       prod_reg, prod_next;
    logic        out_valid_reg, out_valid_next;
    word_t       out_data_reg, out_data_next;

    logic        wr_en;
    addr_t       wr_addr;
    word_t       wr_data;
    addr_t       rd_addr_a;
    addr_t       rd_addr_b;
    word_t       rd_data_a;
    word_t       rd_data_b;

    word_t       sub_a, sub_b, sub_res;
    logic [47:0] prod_full;
    logic [31:0] seed_neg;
    logic [6:0]  pos_sum;
    addr_t       read_step, lag_step, mix_other;
    logic        s_beat;

    srg_ram u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

    // Shared subtractor, wraps to the word width
    assign sub_res   = sub_a - sub_b;
    assign prod_full = diff_reg * DRAW_MUL;
    assign seed_neg  = 32'd0 - s_tdata;

    // Circular index steps and lag partner
    assign read_step = (read_index_reg == LAST_POS) ? 6'd1 : read_index_reg + 6'd1;
    assign lag_step  = (lag_index_reg == LAST_POS) ? 6'd1 : lag_index_reg + 6'd1;
    assign mix_other = (cnt_reg <= LAG_SPLIT) ? cnt_reg + LAG_FWD : cnt_reg - LAG_BACK;
    assign pos_sum   = {1'b0, pos_reg} + {1'b0, SCATTER_STEP};

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        m_next          = m_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        pass_next       = pass_reg;
        read_index_next = read_index_reg;
        lag_index_next  = lag_index_reg;
        diff_next       = diff_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = k_reg;
        rd_addr_a       = read_step;
        rd_addr_b       = lag_step;
        sub_a           = rd_data_a;
        sub_b           = rd_data_b;

        case (state_reg)
            S_IDLE: begin
                if (s_beat) begin
                    if (s_tuser) begin
                        read_index_next = read_step;
                        lag_index_next  = lag_step;
                        state_next      = S_DRAW_SUB;
                    end else begin
                        mag_next   = s_tdata[31] ? seed_neg[WORD_W-1:0]
                                                 : s_tdata[WORD_W-1:0];
                        state_next = S_SEED;
                    end
                end
            end
            // Store the start value at the last position
            S_SEED: begin
                sub_a      = SEED_BASE;
                sub_b      = mag_reg;
                wr_en      = 1'b1;
                wr_addr    = LAST_POS;
                wr_data    = sub_res;
                m_next     = sub_res;
                k_next     = 31'd1;
                pos_next   = SCATTER_STEP;
                cnt_next   = 6'd1;
                state_next = S_SCAT;
            end
            // Scatter the running values by 21 mod 55
            S_SCAT: begin
                sub_a   = m_reg;
                sub_b   = k_reg;
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                wr_data = k_reg;
                k_next  = sub_res;
                m_next  = k_reg;
                pos_next = (pos_sum >= 7'(TABLE_LEN)) ? 6'(pos_sum - 7'(TABLE_LEN))
                                                       : pos_sum[ADDR_W-1:0];
                if (cnt_reg == LAST_SCATTER) begin
                    cnt_next   = 6'd1;
                    pass_next  = 2'd0;
                    state_next = S_MIX_RD;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_MIX_RD: begin
                rd_addr_a  = cnt_reg;
                rd_addr_b  = mix_other;
                state_next = S_MIX_WR;
            end
            // Subtract the lag partner and advance through the passes
            S_MIX_WR: begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_data = sub_res;
                if (cnt_reg == LAST_SCATTER) begin
                    cnt_next  = 6'd1;
                    pass_next = pass_reg + 2'd1;
                    if (pass_reg == 2'd3) begin
                        read_index_next = 6'd0;
                        lag_index_next  = LAG_START;
                        state_next      = S_IDLE;
                    end else begin
                        state_next = S_MIX_RD;
                    end
                end else begin
                    cnt_next   = cnt_reg + 6'd1;
                    state_next = S_MIX_RD;
                end
            end
            S_DRAW_SUB: begin
                diff_next  = sub_res;
                state_next = S_DRAW_MUL;
            end
            S_DRAW_MUL: begin
                prod_next  = prod_full[WORD_W-1:0];
                state_next = S_DRAW_WR;
            end
            // Write back and hand the word to the output register
            S_DRAW_WR: begin
                if (!out_valid_reg || m_tready) begin
                    wr_en          = 1'b1;
                    wr_addr        = read_index_reg;
                    wr_data        = prod_reg + DRAW_ADD;
                    out_valid_next = 1'b1;
                    out_data_next  = prod_reg + DRAW_ADD;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state; reset reseeds with zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_SEED;
            mag_reg        <= '0;
            cnt_reg        <= '0;
            pass_reg       <= '0;
            read_index_reg <= '0;
            lag_index_reg  <= LAG_START;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            mag_reg        <= mag_next;
            cnt_reg        <= cnt_next;
            pass_reg       <= pass_next;
            read_index_reg <= read_index_next;
            lag_index_reg  <= lag_index_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        m_reg        <= m_next;
        k_reg        <= k_next;
        pos_reg      <= pos_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    // A draw beat is always followed by a valid word on the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && s_tuser) |-> ##4 m_tvalid)
        else $error("draw beat produced no result");

    // The lag index leads the read index by 31 positions mod 55
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |->
            ((read_index_reg == 6'd0 && lag_index_reg == LAG_START) ||
             (read_index_reg >= 6'd1 && read_index_reg <= LAG_SPLIT &&
              lag_index_reg == read_index_reg + LAG_FWD) ||
             (read_index_reg > LAG_SPLIT && read_index_reg <= LAST_POS &&
              lag_index_reg == read_index_reg - LAG_BACK)))
        else $error("read and lag indices out of step");

    // A seed beat never raises a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && !s_tuser && !out_valid_reg) |=> !m_tvalid)
        else $error("seed beat produced a result");

endmodule

// ----- sim/subtractive_random_generator_tb.sv -----
// Self-checking testbench for subtractive_random_generator: seed and draw beats
// with random gaps and back-pressure, checked against an in-bench lag-table model.
// Depends on srg_pkg and the generator RTL (with srg_ram).
module subtractive_random_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srg_pkg::*;

    localparam bit MODE_SEED = 1'b0;
    localparam bit MODE_DRAW = 1'b1;

    localparam int RANDOM_BEATS  = 1550;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 5000;
    localparam int DRAIN_CYCLES  = 600;
    localparam int REPORT_LIMIT  = 10;

    // Tracks the generator state and the words still owed by the block
    class draw_checker;
        word_t lag_words [RAM_DEPTH];
        addr_t rd_pos;
        addr_t lag_pos;
        word_t owed_words [$];
        int    mismatches;

        function new();
            mismatches = 0;
            reseed(32'd0);
        endfunction

        // Rebuild the lag table from the magnitude of a signed seed
        function void reseed(logic [31:0] seed_bits);
            logic [31:0] mag;
            logic [31:0] m;
            logic [31:0] k;
            int i;
            int pass;
            int pos;
            int other;
            mag = seed_bits[31] ? (32'd0 - seed_bits) : seed_bits;
            m = (32'(SEED_BASE) - mag) & 32'h7fff_ffff;
            k = 32'd1;
            foreach (lag_words[j]) lag_words[j] = '0;
            lag_words[TABLE_LEN] = m[WORD_W-1:0];
            // scatter walk
            for (i = 1; i < TABLE_LEN; i++) begin
                pos = (int'(SCATTER_STEP) * i) % TABLE_LEN;
                lag_words[pos] = k[WORD_W-1:0];
                k = (m - k) & 32'h7fff_ffff;
                m = {1'b0, lag_words[pos]};
            end
            // four mixing passes
            for (pass = 0; pass < 4; pass++) begin
                for (i = 1; i < TABLE_LEN; i++) begin
                    other = 1 + (i + 30) % TABLE_LEN;
                    lag_words[i] = lag_words[i] - lag_words[other];
                end
            end
            rd_pos  = '0;
            lag_pos = LAG_START;
        endfunction

        // Advance both indices and form the next word
        function word_t next_word();
            word_t       diff;
            logic [31:0] prod;
            rd_pos  = (rd_pos  == LAST_POS) ? addr_t'(1) : rd_pos + 1'b1;
            lag_pos = (lag_pos == LAST_POS) ? addr_t'(1) : lag_pos + 1'b1;
            diff = lag_words[rd_pos] - lag_words[lag_pos];
            prod = 32'(diff) * 32'(DRAW_MUL) + 32'(DRAW_ADD);
            lag_words[rd_pos] = prod[WORD_W-1:0];
            return prod[WORD_W-1:0];
        endfunction

        function void note_input(bit mode, logic [31:0] seed_bits);
            if (mode == MODE_SEED) reseed(seed_bits);
            else owed_words.push_back(next_word());
        endfunction

        function void check_result(logic [31:0] beat);
            logic [31:0] want;
            if (owed_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result beat %h", beat);
            end else begin
                want = {1'b0, owed_words.pop_front()};
                if (beat !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("word mismatch: expected %h got %h", want, beat);
                end
            end
        endfunction

        function int outstanding();
            return owed_words.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;    // [31:0] seed (signed)
    logic        s_tuser = 1'b0;  // [0] mode: 0 seed, 1 draw
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [30:0] value, [31] zero

    bit          hold_req = 1'b0;
    bit          steady = 1'b0;
    int          idle_cycles = 0;
    draw_checker chk = new();

    subtractive_random_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one beat and hold it until the block takes it
    task automatic send_beat(bit mode, logic [31:0] seed_bits);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = seed_bits;
        do @(posedge aclk); while (!s_tready);
        chk.note_input(mode, seed_bits);
    endtask

    // Drop valid for the given gap with junk on the data lines
    task automatic idle_sender(int n);
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata  = $urandom;
            s_tuser  = 1'($urandom_range(0, 1));
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    task automatic run_item(bit mode, logic [31:0] seed_bits);
        send_beat(mode, seed_bits);
        if (!steady) idle_sender(pick_gap());
    endtask

    // Stop offering and wait until every owed word has arrived
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (chk.outstanding() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_seed();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom;
        if (r < 6) return 32'($signed($urandom_range(0, 200)) - 100);
        if (r < 8) return 32'(SEED_BASE) + 32'($signed($urandom_range(0, 8)) - 4);
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return 32'd0;
        endcase
    endfunction

    // Result side: random ready, one long hold-off on request
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                m_tready = 1'b1;
            end else if (steady || $urandom_range(0, 9) < 7) begin
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b0;
                n = pick_gap();
                repeat (n) @(negedge aclk);
            end
        end
    end

    // Check result beats and watch for a stalled block
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) chk.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int n;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: draws from the reset seeding, then the edge seeds
        run_item(MODE_DRAW, $urandom);
        run_item(MODE_DRAW, 32'hffff_ffff);
        run_item(MODE_DRAW, 32'h0000_0000);
        run_item(MODE_SEED, 32'h8000_0000);  // most negative seed
        run_item(MODE_DRAW, $urandom);
        run_item(MODE_DRAW, $urandom);
        run_item(MODE_SEED, 32'h7fff_ffff);
        run_item(MODE_DRAW, $urandom);
        run_item(MODE_SEED, 32'hffff_ffff);
        run_item(MODE_DRAW, $urandom);
        run_item(MODE_SEED, 32'(SEED_BASE));  // start value of zero
        run_item(MODE_DRAW, $urandom);
        run_item(MODE_SEED, 32'(SEED_BASE) + 32'd1);  // difference wraps
        run_item(MODE_DRAW, $urandom);
        run_item(MODE_SEED, 32'd0 - 32'(SEED_BASE) - 32'd1);
        run_item(MODE_DRAW, $urandom);
        run_item(MODE_SEED, 32'd0);
        run_item(MODE_DRAW, $urandom);
        run_item(MODE_DRAW, $urandom);
        run_item(MODE_SEED, 32'd1);
        run_item(MODE_DRAW, $urandom);

        // Random: mostly draws, occasional reseeds
        for (n = 0; n < RANDOM_BEATS; n++) begin
            if (n == 300) hold_req = 1'b1;
            if (n == 800) wait_drained();
            steady = (n >= 500 && n < 650);
            if ($urandom_range(0, 99) < 4) run_item(MODE_SEED, pick_seed());
            else run_item(MODE_DRAW, $urandom);
        end
        steady = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (chk.outstanding() != 0)
            $display("%0d expected words never arrived", chk.outstanding());
        if (chk.mismatches == 0 && chk.outstanding() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
